### rtl/vnu_pkg.sv
// vnu_pkg: shared constants for the vector4 normalizer.
// No dependencies.
package vnu_pkg;
	localparam int UNIT_BITS = 16;
	localparam int UNIT_FRAC = 14;
	localparam int QUOT_BITS = UNIT_FRAC + 1;
endpackage

### rtl/vnu_sqrt_stage.sv
// vnu_sqrt_stage: one restoring square-root step (one result bit).
// Standalone arithmetic; no package use.
module vnu_sqrt_stage #(
	parameter int SUM_BITS = 34,
	parameter int ROOT_BITS = 17,
	parameter int STEP = 0
) (
	input  logic [SUM_BITS-1:0]  rem_in,
	input  logic [ROOT_BITS-1:0] root_in,
	output logic [SUM_BITS-1:0]  rem_out,
	output logic [ROOT_BITS-1:0] root_out
);
	localparam int SH = 2 * (ROOT_BITS - 1 - STEP);
	logic [SUM_BITS+1:0] trial;
	logic [SUM_BITS+1:0] rem_w;

	// try root bit: (4*root+1) << SH against remainder
	always_comb begin
		trial = ({{(SUM_BITS+2-ROOT_BITS){1'b0}}, root_in} << (SH + 2))
			| ({{(SUM_BITS+1){1'b0}}, 1'b1} << SH);
		rem_w = {2'b00, rem_in};
		if (rem_w >= trial) begin
			rem_out = SUM_BITS'(rem_w - trial);
			root_out = {root_in[ROOT_BITS-2:0], 1'b1};
		end else begin
			rem_out = rem_in;
			root_out = {root_in[ROOT_BITS-2:0], 1'b0};
		end
	end
endmodule

### rtl/vnu_div_stage.sv
// vnu_div_stage: one restoring division step for four lanes sharing a divisor.
// Standalone arithmetic; no package use.
module vnu_div_stage #(
	parameter int DEN_BITS = 17
) (
	input  logic [DEN_BITS-1:0] den,
	input  logic [DEN_BITS:0]   rem_in  [4],
	input  logic                nbit    [4],
	output logic [DEN_BITS:0]   rem_out [4],
	output logic                qbit    [4]
);
	logic [DEN_BITS+1:0] sh [4];
	// shift in next dividend bit, subtract if it fits
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sh[i] = {rem_in[i], nbit[i]};
			if (sh[i] >= {1'b0, 1'b0, den}) begin
				qbit[i] = 1'b1;
				rem_out[i] = (DEN_BITS+1)'(sh[i] - {2'b00, den});
			end else begin
				qbit[i] = 1'b0;
				rem_out[i] = sh[i][DEN_BITS:0];
			end
		end
	end
endmodule

### rtl/vector4_normalizer_unit.sv
// vector4_normalizer_unit: streaming 4D vector magnitude and normalization.
// Pipeline: 3 input stages, CB+1 root steps, CB+14 divide steps and one output
// register lie between the start transfer and done.
// Throughput: one vector per cycle; one register stage per sqrt and divide bit
// sets the depth. Each result shows for one cycle with done; no stall exists.
// Reset clears valid bits only (arst_n, asynchronous, active low).
// Uses vnu_pkg, vnu_sqrt_stage, vnu_div_stage.
module vector4_normalizer_unit #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COMPONENT_BITS-1:0] comp_x,
	input  logic signed [COMPONENT_BITS-1:0] comp_y,
	input  logic signed [COMPONENT_BITS-1:0] comp_z,
	input  logic signed [COMPONENT_BITS-1:0] comp_w,
	output logic                          done,
	output logic [COMPONENT_BITS:0]       length,
	output logic signed [vnu_pkg::UNIT_BITS-1:0] unit_x,
	output logic signed [vnu_pkg::UNIT_BITS-1:0] unit_y,
	output logic signed [vnu_pkg::UNIT_BITS-1:0] unit_z,
	output logic signed [vnu_pkg::UNIT_BITS-1:0] unit_w,
	output logic                          zero_vector
);
	localparam int CB = COMPONENT_BITS;
	localparam int RB = CB + 1;            // root / divisor width
	localparam int SB = 2 * RB;            // sum width, holds 2^(2CB)
	localparam int NB = CB + vnu_pkg::UNIT_FRAC; // dividend bits
	localparam int QB = vnu_pkg::QUOT_BITS;

	assign busy = 1'b0;

	// stage 1: magnitudes and signs
	logic          v_s1;
	logic [CB-1:0] mag_s1 [4];
	logic          neg_s1 [4];
	logic [CB-1:0] cin [4];
	assign cin[0] = comp_x;
	assign cin[1] = comp_y;
	assign cin[2] = comp_z;
	assign cin[3] = comp_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			neg_s1[i] <= cin[i][CB-1];
			mag_s1[i] <= cin[i][CB-1] ? CB'(~cin[i] + 1'b1) : cin[i];
		end
	end

	// stage 2: squares
	logic          v_s2;
	logic [CB-1:0] mag_s2 [4];
	logic          neg_s2 [4];
	logic [SB-1:0] sq_s2 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			mag_s2[i] <= mag_s1[i];
			neg_s2[i] <= neg_s1[i];
			sq_s2[i] <= SB'({{CB{1'b0}}, mag_s1[i]} * {{CB{1'b0}}, mag_s1[i]});
		end
	end

	// stage 3: sum of squares
	logic          v_s3;
	logic [CB-1:0] mag_s3 [4];
	logic          neg_s3 [4];
	logic [SB-1:0] sum_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2] + sq_s2[3];
	end

	// square root: one bit per registered stage
	logic          sv   [RB+1];
	logic [SB-1:0] srem [RB+1];
	logic [RB-1:0] sroot[RB+1];
	logic [CB-1:0] smag [RB+1][4];
	logic          sneg [RB+1][4];
	assign sv[0] = v_s3;
	assign srem[0] = sum_s3;
	assign sroot[0] = '0;
	assign smag[0] = mag_s3;
	assign sneg[0] = neg_s3;

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		logic [SB-1:0] rem_n;
		logic [RB-1:0] root_n;
		vnu_sqrt_stage #(.SUM_BITS(SB), .ROOT_BITS(RB), .STEP(k)) u_st (
			.rem_in(srem[k]), .root_in(sroot[k]),
			.rem_out(rem_n), .root_out(root_n)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else sv[k+1] <= sv[k];
		end
		always_ff @(posedge clk) begin
			srem[k+1] <= rem_n;
			sroot[k+1] <= root_n;
			smag[k+1] <= smag[k];
			sneg[k+1] <= sneg[k];
		end
	end

	// division: dividend mag<<14, one quotient bit per stage
	logic          dv   [NB+1];
	logic [RB-1:0] dden [NB+1];
	logic [RB:0]   drem [NB+1][4];
	logic [NB-1:0] dnum [NB+1][4];
	logic [QB-1:0] dq   [NB+1][4];
	logic          dneg [NB+1][4];
	assign dv[0] = sv[RB];
	assign dden[0] = sroot[RB];
	for (genvar i = 0; i < 4; i++) begin : g_din
		assign drem[0][i] = '0;
		assign dnum[0][i] = {smag[RB][i], {vnu_pkg::UNIT_FRAC{1'b0}}};
		assign dq[0][i] = '0;
		assign dneg[0][i] = sneg[RB][i];
	end

	for (genvar k = 0; k < NB; k++) begin : g_div
		logic [RB:0] rem_n [4];
		logic        qb    [4];
		logic        nb    [4];
		for (genvar i = 0; i < 4; i++) begin : g_nb
			assign nb[i] = dnum[k][i][NB-1];
		end
		vnu_div_stage #(.DEN_BITS(RB)) u_st (
			.den(dden[k]), .rem_in(drem[k]), .nbit(nb),
			.rem_out(rem_n), .qbit(qb)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else dv[k+1] <= dv[k];
		end
		always_ff @(posedge clk) begin
			dden[k+1] <= dden[k];
			for (int i = 0; i < 4; i++) begin
				drem[k+1][i] <= rem_n[i];
				dnum[k+1][i] <= dnum[k][i] << 1;
				dq[k+1][i] <= {dq[k][i][QB-2:0], qb[i]};
				dneg[k+1][i] <= dneg[k][i];
			end
		end
	end

	// output register: sign, zero forcing
	logic [vnu_pkg::UNIT_BITS-1:0] uo [4];
	logic                          zero_w;
	assign zero_w = (dden[NB] == '0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv[NB];
	end
	always_ff @(posedge clk) begin
		length <= dden[NB];
		zero_vector <= zero_w;
		for (int i = 0; i < 4; i++) begin
			if (zero_w) uo[i] <= '0;
			else if (dneg[NB][i])
				uo[i] <= vnu_pkg::UNIT_BITS'(~{1'b0, dq[NB][i]} + 1'b1);
			else uo[i] <= {1'b0, dq[NB][i]};
		end
	end
	assign unit_x = uo[0];
	assign unit_y = uo[1];
	assign unit_z = uo[2];
	assign unit_w = uo[3];
endmodule
